### hw/rtl/stlpg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stlpg_pkg;

    localparam int GLYPH_W     = 5;
    localparam int GLYPH_H     = 7;
    localparam int CELL_COLS   = 6;
    localparam int RECIP_SHIFT = 16;
    localparam int DIV6_MUL    = 342;
    localparam int DIV6_SHIFT  = 11;

    typedef enum logic [1:0] {
        CFG_GLYPH_SCALE = 2'd0,
        CFG_LINE_TOP    = 2'd1,
        CFG_TEXT_COLOR  = 2'd2,
        CFG_TEXT_LENGTH = 2'd3
    } t_cfg_reg;

    typedef logic [GLYPH_W*GLYPH_H-1:0] t_glyph;

    function automatic t_glyph pack(input logic [6:0] c0, input logic [6:0] c1,
                                    input logic [6:0] c2, input logic [6:0] c3,
                                    input logic [6:0] c4);
        return {c4, c3, c2, c1, c0};
    endfunction

    // ceil(2^16 / s), exact floor division for 8-bit dividends
    function automatic logic [16:0] recip(input logic [2:0] s);
        logic [16:0] m;
        case (s)
            3'd2:    m = 17'd32768;
            3'd3:    m = 17'd21846;
            3'd4:    m = 17'd16384;
            3'd5:    m = 17'd13108;
            3'd6:    m = 17'd10923;
            3'd7:    m = 17'd9363;
            default: m = 17'd65536;
        endcase
        return m;
    endfunction

    function automatic t_glyph glyph_cols(input logic [7:0] code);
        logic [7:0] c;
        t_glyph     g;
        c = (code >= 8'h61 && code <= 8'h7A) ? code - 8'd32 : code;
        case (c)
            8'h20: g = pack(7'h00, 7'h00, 7'h00, 7'h00, 7'h00);
            8'h30: g = pack(7'h3E, 7'h51, 7'h49, 7'h45, 7'h3E);
            8'h31: g = pack(7'h00, 7'h42, 7'h7F, 7'h40, 7'h00);
            8'h32: g = pack(7'h42, 7'h61, 7'h51, 7'h49, 7'h46);
            8'h33: g = pack(7'h21, 7'h41, 7'h45, 7'h4B, 7'h31);
            8'h34: g = pack(7'h18, 7'h14, 7'h12, 7'h7F, 7'h10);
            8'h35: g = pack(7'h27, 7'h45, 7'h45, 7'h45, 7'h39);
            8'h36: g = pack(7'h3C, 7'h4A, 7'h49, 7'h49, 7'h30);
            8'h37: g = pack(7'h01, 7'h71, 7'h09, 7'h05, 7'h03);
            8'h38: g = pack(7'h36, 7'h49, 7'h49, 7'h49, 7'h36);
            8'h39: g = pack(7'h06, 7'h49, 7'h49, 7'h29, 7'h1E);
            8'h41: g = pack(7'h7E, 7'h11, 7'h11, 7'h11, 7'h7E);
            8'h42: g = pack(7'h7F, 7'h49, 7'h49, 7'h49, 7'h36);
            8'h43: g = pack(7'h3E, 7'h41, 7'h41, 7'h41, 7'h22);
            8'h44: g = pack(7'h7F, 7'h41, 7'h41, 7'h22, 7'h1C);
            8'h45: g = pack(7'h7F, 7'h49, 7'h49, 7'h49, 7'h41);
            8'h46: g = pack(7'h7F, 7'h09, 7'h09, 7'h09, 7'h01);
            8'h47: g = pack(7'h3E, 7'h41, 7'h49, 7'h49, 7'h7A);
            8'h48: g = pack(7'h7F, 7'h08, 7'h08, 7'h08, 7'h7F);
            8'h49: g = pack(7'h00, 7'h41, 7'h7F, 7'h41, 7'h00);
            8'h4A: g = pack(7'h20, 7'h40, 7'h41, 7'h3F, 7'h01);
            8'h4B: g = pack(7'h7F, 7'h08, 7'h14, 7'h22, 7'h41);
            8'h4C: g = pack(7'h7F, 7'h40, 7'h40, 7'h40, 7'h40);
            8'h4D: g = pack(7'h7F, 7'h02, 7'h0C, 7'h02, 7'h7F);
            8'h4E: g = pack(7'h7F, 7'h04, 7'h08, 7'h10, 7'h7F);
            8'h4F: g = pack(7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E);
            8'h50: g = pack(7'h7F, 7'h09, 7'h09, 7'h09, 7'h06);
            8'h51: g = pack(7'h3E, 7'h41, 7'h51, 7'h21, 7'h5E);
            8'h52: g = pack(7'h7F, 7'h09, 7'h19, 7'h29, 7'h46);
            8'h53: g = pack(7'h46, 7'h49, 7'h49, 7'h49, 7'h31);
            8'h54: g = pack(7'h01, 7'h01, 7'h7F, 7'h01, 7'h01);
            8'h55: g = pack(7'h3F, 7'h40, 7'h40, 7'h40, 7'h3F);
            8'h56: g = pack(7'h1F, 7'h20, 7'h40, 7'h20, 7'h1F);
            8'h57: g = pack(7'h3F, 7'h40, 7'h38, 7'h40, 7'h3F);
            8'h58: g = pack(7'h63, 7'h14, 7'h08, 7'h14, 7'h63);
            8'h59: g = pack(7'h07, 7'h08, 7'h70, 7'h08, 7'h07);
            8'h5A: g = pack(7'h61, 7'h51, 7'h49, 7'h45, 7'h43);
            8'h2E: g = pack(7'h00, 7'h60, 7'h60, 7'h00, 7'h00);
            8'h2D: g = pack(7'h08, 7'h08, 7'h08, 7'h08, 7'h08);
            8'h3A: g = pack(7'h00, 7'h36, 7'h36, 7'h00, 7'h00);
            8'h2F: g = pack(7'h20, 7'h10, 7'h08, 7'h04, 7'h02);
            8'h5F: g = pack(7'h40, 7'h40, 7'h40, 7'h40, 7'h40);
            default: g = pack(7'h02, 7'h01, 7'h51, 7'h09, 7'h06);
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/scaled_text_line_pixel_generator_core.sv
// A pixel query's result appears on o_valid after stages s1 to s6 and the output register.
// Throughput: one beat per cycle unless stalled; six register stages plus the output register, each
// holding its beat until the next one frees; beats enter while a result waits, until stages fill.
// Reset: config registers return to scale 1, top 0, colour 0xFFFF, length 0; pipeline empties.
// The line store gets no reset and no clearing pass; a slot reads as garbage until written.
`timescale 1ns / 1ps
`default_nettype none

module scaled_text_line_pixel_generator_core #(
    parameter int MAX_CHARS   = 32,
    parameter int LINE_WIDTH  = 160,
    parameter int LINE_HEIGHT = 80
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_mode,
    input  wire logic [4:0]  i_char_slot,
    input  wire logic [7:0]  i_char_code,
    input  wire logic [7:0]  i_pixel_x,
    input  wire logic [6:0]  i_pixel_y,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_lit,
    output logic [15:0]      o_pixel_color
);

    localparam int AW = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
    localparam int XW = $clog2(LINE_WIDTH + 8);
    localparam int CW = (XW > 8) ? XW : 8;
    localparam int GW = stlpg_pkg::GLYPH_W;
    localparam int GH = stlpg_pkg::GLYPH_H;

    localparam int LIM1 = (LINE_WIDTH / 6  < MAX_CHARS) ? LINE_WIDTH / 6  : MAX_CHARS;
    localparam int LIM2 = (LINE_WIDTH / 12 < MAX_CHARS) ? LINE_WIDTH / 12 : MAX_CHARS;
    localparam int LIM3 = (LINE_WIDTH / 18 < MAX_CHARS) ? LINE_WIDTH / 18 : MAX_CHARS;
    localparam int LIM4 = (LINE_WIDTH / 24 < MAX_CHARS) ? LINE_WIDTH / 24 : MAX_CHARS;
    localparam int LIM5 = (LINE_WIDTH / 30 < MAX_CHARS) ? LINE_WIDTH / 30 : MAX_CHARS;
    localparam int LIM6 = (LINE_WIDTH / 36 < MAX_CHARS) ? LINE_WIDTH / 36 : MAX_CHARS;
    localparam int LIM7 = (LINE_WIDTH / 42 < MAX_CHARS) ? LINE_WIDTH / 42 : MAX_CHARS;

    logic [2:0]  r_glyph_scale;
    logic [6:0]  r_line_top;
    logic [15:0] r_text_color;
    logic [5:0]  r_text_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glyph_scale <= 3'd1;
            r_line_top    <= 7'd0;
            r_text_color  <= 16'hFFFF;
            r_text_length <= 6'd0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                stlpg_pkg::CFG_GLYPH_SCALE: r_glyph_scale <= i_cfg_data[2:0];
                stlpg_pkg::CFG_LINE_TOP:    r_line_top    <= i_cfg_data[6:0];
                stlpg_pkg::CFG_TEXT_COLOR:  r_text_color  <= i_cfg_data;
                stlpg_pkg::CFG_TEXT_LENGTH: r_text_length <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy_out;

    logic        r_s1_v, r_s1_mode, r_s1_off;
    logic [4:0]  r_s1_slot;
    logic [7:0]  r_s1_code, r_s1_px;
    logic [6:0]  r_s1_py, r_s1_n;
    logic [2:0]  r_s1_s;
    logic [5:0]  r_s1_cell;

    logic        r_s2_v, r_s2_mode, r_s2_miss;
    logic [4:0]  r_s2_slot;
    logic [7:0]  r_s2_code, r_s2_rel;
    logic [6:0]  r_s2_dy, r_s2_n;
    logic [2:0]  r_s2_s;

    logic        r_s3_v, r_s3_mode, r_s3_miss;
    logic [4:0]  r_s3_slot;
    logic [7:0]  r_s3_code, r_s3_t;
    logic [6:0]  r_s3_row, r_s3_n;

    logic        r_s4_v, r_s4_mode, r_s4_miss;
    logic [4:0]  r_s4_slot;
    logic [7:0]  r_s4_code;
    logic [5:0]  r_s4_cslot;
    logic [2:0]  r_s4_col, r_s4_row;

    logic        r_s5_v, r_s5_miss;
    logic [7:0]  r_s5_code;
    logic [2:0]  r_s5_col, r_s5_row;

    logic        r_s6_v, r_s6_miss;
    logic [6:0]  r_s6_bits;
    logic [2:0]  r_s6_row;

    logic        r_out_valid, r_out_lit;
    logic [15:0] r_out_color;

    logic [7:0]  r_store [MAX_CHARS];

    assign rdy_out = !r_out_valid || !i_stall;
    assign rdy6    = !r_s6_v || rdy_out;
    assign rdy5    = !r_s5_v || rdy6;
    assign rdy4    = !r_s4_v || rdy5;
    assign rdy3    = !r_s3_v || rdy4;
    assign rdy2    = !r_s2_v || rdy3;
    assign rdy1    = !r_s1_v || rdy2;
    assign o_stall = !rdy1;

    logic [2:0]  n_s1_s;
    logic [5:0]  n_s1_cell;
    logic [6:0]  lim, len_w;

    always_comb begin
        n_s1_s    = (r_glyph_scale == 3'd0) ? 3'd1 : r_glyph_scale;
        n_s1_cell = (6'(n_s1_s) << 2) + (6'(n_s1_s) << 1);
        case (n_s1_s)
            3'd2:    lim = 7'(LIM2);
            3'd3:    lim = 7'(LIM3);
            3'd4:    lim = 7'(LIM4);
            3'd5:    lim = 7'(LIM5);
            3'd6:    lim = 7'(LIM6);
            3'd7:    lim = 7'(LIM7);
            default: lim = 7'(LIM1);
        endcase
        len_w = 7'(r_text_length);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (rdy1) begin
            r_s1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_s1_mode <= i_mode;
            r_s1_slot <= i_char_slot;
            r_s1_code <= i_char_code;
            r_s1_px   <= i_pixel_x;
            r_s1_py   <= i_pixel_y;
            r_s1_off  <= (11'(i_pixel_x) >= 11'(LINE_WIDTH)) ||
                         (11'(i_pixel_y) >= 11'(LINE_HEIGHT));
            r_s1_s    <= n_s1_s;
            r_s1_cell <= n_s1_cell;
            r_s1_n    <= (len_w < lim) ? len_w : lim;
        end
    end

    logic [12:0]   prod;
    logic [XW-1:0] x_sum, x0;
    logic [CW-1:0] px_w, x0_w, rel_w;

    always_comb begin
        prod  = 13'(r_s1_n) * 13'(r_s1_cell);
        x_sum = XW'(LINE_WIDTH) - XW'(prod) + XW'(r_s1_s);
        x0    = x_sum >> 1;
        px_w  = CW'(r_s1_px);
        x0_w  = CW'(x0);
        rel_w = px_w - x0_w;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (rdy2) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_s2_mode <= r_s1_mode;
            r_s2_slot <= r_s1_slot;
            r_s2_code <= r_s1_code;
            r_s2_miss <= r_s1_off || (px_w < x0_w) || (r_s1_py < r_line_top);
            r_s2_rel  <= rel_w[7:0];
            r_s2_dy   <= r_s1_py - r_line_top;
            r_s2_n    <= r_s1_n;
            r_s2_s    <= r_s1_s;
        end
    end

    logic [16:0] rcp;
    logic [24:0] t_prod;
    logic [23:0] row_prod;

    always_comb begin
        rcp      = stlpg_pkg::recip(r_s2_s);
        t_prod   = 25'(r_s2_rel) * 25'(rcp);
        row_prod = 24'(r_s2_dy) * 24'(rcp);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else if (rdy3) begin
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_s3_mode <= r_s2_mode;
            r_s3_slot <= r_s2_slot;
            r_s3_code <= r_s2_code;
            r_s3_miss <= r_s2_miss;
            r_s3_t    <= t_prod[stlpg_pkg::RECIP_SHIFT +: 8];
            r_s3_row  <= row_prod[stlpg_pkg::RECIP_SHIFT +: 7];
            r_s3_n    <= r_s2_n;
        end
    end

    logic [16:0] q_prod;
    logic [5:0]  cslot;
    logic [7:0]  col_w;

    always_comb begin
        q_prod = 17'(r_s3_t) * 17'(stlpg_pkg::DIV6_MUL);
        cslot  = q_prod[stlpg_pkg::DIV6_SHIFT +: 6];
        col_w  = r_s3_t - 8'((8'(cslot) << 2) + (8'(cslot) << 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_v <= 1'b0;
        end else if (rdy4) begin
            r_s4_v <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r_s4_mode  <= r_s3_mode;
            r_s4_slot  <= r_s3_slot;
            r_s4_code  <= r_s3_code;
            r_s4_miss  <= r_s3_miss || (7'(cslot) >= r_s3_n) ||
                          (col_w >= 8'(stlpg_pkg::GLYPH_W)) ||
                          (r_s3_row >= 7'(stlpg_pkg::GLYPH_H));
            r_s4_cslot <= cslot;
            r_s4_col   <= col_w[2:0];
            r_s4_row   <= r_s3_row[2:0];
        end
    end

    logic [6:0]    wr_w, rd_w;
    logic [AW-1:0] wr_addr, rd_addr;
    logic          wr_en;

    always_comb begin
        wr_w    = 7'(r_s4_slot);
        rd_w    = r_s4_miss ? 7'd0 : 7'(r_s4_cslot);
        wr_addr = wr_w[AW-1:0];
        rd_addr = rd_w[AW-1:0];
        wr_en   = r_s4_v && !r_s4_mode && rdy5 && (wr_w < 7'(MAX_CHARS));
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[wr_addr] <= r_s4_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy5) begin
            r_s5_code <= r_store[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_v <= 1'b0;
        end else if (rdy5) begin
            r_s5_v <= r_s4_v && r_s4_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy5) begin
            r_s5_miss <= r_s4_miss;
            r_s5_col  <= r_s4_col;
            r_s5_row  <= r_s4_row;
        end
    end

    stlpg_pkg::t_glyph glyph;
    logic [GH-1:0]     col_bits;

    always_comb begin
        glyph = stlpg_pkg::glyph_cols(r_s5_code);
        case (r_s5_col)
            3'd0:    col_bits = glyph[0*GH +: GH];
            3'd1:    col_bits = glyph[1*GH +: GH];
            3'd2:    col_bits = glyph[2*GH +: GH];
            3'd3:    col_bits = glyph[3*GH +: GH];
            3'd4:    col_bits = glyph[(GW-1)*GH +: GH];
            default: col_bits = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_v <= 1'b0;
        end else if (rdy6) begin
            r_s6_v <= r_s5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy6) begin
            r_s6_miss <= r_s5_miss;
            r_s6_bits <= col_bits;
            r_s6_row  <= r_s5_row;
        end
    end

    logic [7:0] bits_w;
    logic       n_lit;

    always_comb begin
        bits_w = {1'b0, r_s6_bits};
        n_lit  = !r_s6_miss && bits_w[r_s6_row];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rdy_out) begin
            r_out_valid <= r_s6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_out) begin
            r_out_lit   <= n_lit;
            r_out_color <= n_lit ? {r_text_color[7:0], r_text_color[15:8]} : 16'd0;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_lit         = r_out_lit;
    assign o_pixel_color = r_out_color;

endmodule

`default_nettype wire

### sim/scaled_text_line_pixel_generator_core_tb.sv
`timescale 1ns / 1ps

module scaled_text_line_pixel_generator_core_tb;

    localparam int MAX_CHARS    = 32;
    localparam int LINE_WIDTH   = 160;
    localparam int LINE_HEIGHT  = 80;
    localparam int UNKNOWN_IDX  = 42;
    localparam int DRAIN_CYCLES = 12;
    localparam int STUCK_LIMIT  = 3000;
    localparam int HOLD_OFF     = 400;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_BEATS   = 195;

    typedef struct packed {
        logic       mode;
        logic [4:0] slot;
        logic [7:0] code;
        logic [7:0] px;
        logic [6:0] py;
    } t_beat;

    typedef struct packed {
        logic        lit;
        logic [15:0] color;
    } t_pixel;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_mode = 1'b0;
    logic [4:0]  i_char_slot = '0;
    logic [7:0]  i_char_code = '0;
    logic [7:0]  i_pixel_x = '0;
    logic [6:0]  i_pixel_y = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_lit;
    logic [15:0] o_pixel_color;

    logic [2:0]  scale_cfg = 3'd1;
    logic [6:0]  top_cfg = 7'd0;
    logic [15:0] color_cfg = 16'hFFFF;
    logic [5:0]  length_cfg = 6'd0;
    logic [7:0]  line_chars [0:MAX_CHARS-1];
    logic [39:0] font_rom [0:42];
    string       font_chars;

    t_beat  pending_beats[$];
    t_pixel expected_pixels[$];
    t_beat  src_beat;
    int     beats_queued = 0;
    int     beats_taken = 0;
    int     mismatches = 0;
    int     src_gap = 0;
    logic   src_burst = 1'b0;
    int     sink_wait = 0;
    logic   sink_burst = 1'b0;
    logic   beat_in_taken = 1'b0;
    logic   pixel_taken = 1'b0;
    logic   pressure_req = 1'b0;
    logic   pressure_on = 1'b0;
    int     stuck_cycles = 0;

    scaled_text_line_pixel_generator_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_mode        (i_mode),
        .i_char_slot   (i_char_slot),
        .i_char_code   (i_char_code),
        .i_pixel_x     (i_pixel_x),
        .i_pixel_y     (i_pixel_y),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_lit         (o_lit),
        .o_pixel_color (o_pixel_color)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        font_chars = " 0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ.-:/_?";
        font_rom[0]  = 40'h00_00_00_00_00;
        font_rom[1]  = 40'h3E_51_49_45_3E;
        font_rom[2]  = 40'h00_42_7F_40_00;
        font_rom[3]  = 40'h42_61_51_49_46;
        font_rom[4]  = 40'h21_41_45_4B_31;
        font_rom[5]  = 40'h18_14_12_7F_10;
        font_rom[6]  = 40'h27_45_45_45_39;
        font_rom[7]  = 40'h3C_4A_49_49_30;
        font_rom[8]  = 40'h01_71_09_05_03;
        font_rom[9]  = 40'h36_49_49_49_36;
        font_rom[10] = 40'h06_49_49_29_1E;
        font_rom[11] = 40'h7E_11_11_11_7E;
        font_rom[12] = 40'h7F_49_49_49_36;
        font_rom[13] = 40'h3E_41_41_41_22;
        font_rom[14] = 40'h7F_41_41_22_1C;
        font_rom[15] = 40'h7F_49_49_49_41;
        font_rom[16] = 40'h7F_09_09_09_01;
        font_rom[17] = 40'h3E_41_49_49_7A;
        font_rom[18] = 40'h7F_08_08_08_7F;
        font_rom[19] = 40'h00_41_7F_41_00;
        font_rom[20] = 40'h20_40_41_3F_01;
        font_rom[21] = 40'h7F_08_14_22_41;
        font_rom[22] = 40'h7F_40_40_40_40;
        font_rom[23] = 40'h7F_02_0C_02_7F;
        font_rom[24] = 40'h7F_04_08_10_7F;
        font_rom[25] = 40'h3E_41_41_41_3E;
        font_rom[26] = 40'h7F_09_09_09_06;
        font_rom[27] = 40'h3E_41_51_21_5E;
        font_rom[28] = 40'h7F_09_19_29_46;
        font_rom[29] = 40'h46_49_49_49_31;
        font_rom[30] = 40'h01_01_7F_01_01;
        font_rom[31] = 40'h3F_40_40_40_3F;
        font_rom[32] = 40'h1F_20_40_20_1F;
        font_rom[33] = 40'h3F_40_38_40_3F;
        font_rom[34] = 40'h63_14_08_14_63;
        font_rom[35] = 40'h07_08_70_08_07;
        font_rom[36] = 40'h61_51_49_45_43;
        font_rom[37] = 40'h00_60_60_00_00;
        font_rom[38] = 40'h08_08_08_08_08;
        font_rom[39] = 40'h00_36_36_00_00;
        font_rom[40] = 40'h20_10_08_04_02;
        font_rom[41] = 40'h40_40_40_40_40;
        font_rom[42] = 40'h02_01_51_09_06;
    end

    function automatic void line_geometry(output int s, output int cell_w, output int n,
                                          output int x0);
        s = (scale_cfg == 3'd0) ? 1 : int'(scale_cfg);
        cell_w = 6 * s;
        n = length_cfg;
        if (n > MAX_CHARS) n = MAX_CHARS;
        if (n > LINE_WIDTH / cell_w) n = LINE_WIDTH / cell_w;
        x0 = (LINE_WIDTH - n * cell_w + s) / 2;
    endfunction

    function automatic t_pixel shade_pixel(input logic [7:0] px, input logic [6:0] py);
        int s, cell_w, n, x0, x, y, rel, slot, col, row, g, k;
        logic [7:0] code;
        t_pixel res;
        res = '0;
        x = px;
        y = py;
        line_geometry(s, cell_w, n, x0);
        if (x < LINE_WIDTH && y < LINE_HEIGHT && x >= x0 && y >= int'(top_cfg)) begin
            rel = x - x0;
            slot = rel / cell_w;
            col = (rel % cell_w) / s;
            row = (y - int'(top_cfg)) / s;
            if (slot < n && col < 5 && row < 7) begin
                code = line_chars[slot];
                if (code >= 8'h61 && code <= 8'h7A) code = code - 8'd32;
                g = UNKNOWN_IDX;
                for (k = 0; k < UNKNOWN_IDX; k++)
                    if (font_chars[k] == code) g = k;
                res.lit = font_rom[g][32 - 8 * col + row];
                if (res.lit) res.color = {color_cfg[7:0], color_cfg[15:8]};
            end
        end
        return res;
    endfunction

    task automatic queue_store(input logic [4:0] slot, input logic [7:0] code);
        t_beat b;
        b.mode = 1'b0;
        b.slot = slot;
        b.code = code;
        b.px = 8'($urandom);
        b.py = 7'($urandom);
        pending_beats.push_back(b);
        beats_queued++;
    endtask

    task automatic queue_query(input int x, input int y);
        t_beat b;
        b.mode = 1'b1;
        b.slot = 5'($urandom);
        b.code = 8'($urandom);
        b.px = x[7:0];
        b.py = y[6:0];
        pending_beats.push_back(b);
        beats_queued++;
    endtask

    task automatic queue_random_beat();
        int s, cell_w, n, x0, pick, x, y;
        logic [7:0] code;
        pick = $urandom_range(0, 99);
        line_geometry(s, cell_w, n, x0);
        if (pick < 8) begin
            case ($urandom_range(0, 2))
                0:       code = font_chars[$urandom_range(0, 42)];
                1:       code = 8'(8'h61 + $urandom_range(0, 25));
                default: code = 8'($urandom_range(0, 255));
            endcase
            queue_store(5'($urandom_range(0, 31)), code);
        end else if (pick < 85) begin
            x = x0 - 2 + int'($urandom_range(0, n * cell_w + 4));
            y = int'(top_cfg) - 2 + int'($urandom_range(0, 7 * s + 4));
            if (x < 0) x = 0;
            if (x > 255) x = 255;
            if (y < 0) y = 0;
            if (y > 127) y = 127;
            queue_query(x, y);
        end else begin
            queue_query($urandom_range(0, 255), $urandom_range(0, 127));
        end
    endtask

    task automatic set_reg(input stlpg_pkg::t_cfg_reg idx, input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        case (idx)
            stlpg_pkg::CFG_GLYPH_SCALE: scale_cfg = value[2:0];
            stlpg_pkg::CFG_LINE_TOP:    top_cfg = value[6:0];
            stlpg_pkg::CFG_TEXT_COLOR:  color_cfg = value;
            stlpg_pkg::CFG_TEXT_LENGTH: length_cfg = value[5:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic configure(input int scale, input int top, input int color, input int len);
        set_reg(stlpg_pkg::CFG_GLYPH_SCALE, scale[15:0]);
        set_reg(stlpg_pkg::CFG_LINE_TOP, top[15:0]);
        set_reg(stlpg_pkg::CFG_TEXT_COLOR, color[15:0]);
        set_reg(stlpg_pkg::CFG_TEXT_LENGTH, len[15:0]);
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (beats_taken != beats_queued || expected_pixels.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // source side: hold a beat until taken, then gap and advance
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || beat_in_taken) begin
            if (src_gap != 0) begin
                i_valid <= 1'b0;
                src_gap <= src_gap - 1;
            end else if (pending_beats.size() != 0) begin
                src_beat = pending_beats.pop_front();
                i_valid <= 1'b1;
                i_mode <= src_beat.mode;
                i_char_slot <= src_beat.slot;
                i_char_code <= src_beat.code;
                i_pixel_x <= src_beat.px;
                i_pixel_y <= src_beat.py;
                src_gap <= src_burst ? 0 : $urandom_range(0, 15);
                if ($urandom_range(0, 39) == 0) src_burst <= !src_burst;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // sink side: random stalls after results outside burst mode, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (pressure_req && !pressure_on) begin
            pressure_on <= 1'b1;
            sink_wait <= HOLD_OFF - 1;
            i_stall <= 1'b1;
        end else if (sink_wait != 0) begin
            sink_wait <= sink_wait - 1;
            i_stall <= 1'b1;
        end else if (pixel_taken && !sink_burst) begin
            sink_wait <= $urandom_range(0, 15);
            i_stall <= ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 39) == 0) sink_burst <= 1'b1;
        end else begin
            i_stall <= 1'b0;
            if (pixel_taken && $urandom_range(0, 39) == 0) sink_burst <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_pixel want;
        if (!i_rst_n) begin
            beat_in_taken <= 1'b0;
            pixel_taken <= 1'b0;
        end else begin
            beat_in_taken <= i_valid && !o_stall;
            pixel_taken <= o_valid && !i_stall;
            if (i_valid && !o_stall) begin
                beats_taken++;
                if (!i_mode)
                    line_chars[i_char_slot] = i_char_code;
                else
                    expected_pixels.push_back(shade_pixel(i_pixel_x, i_pixel_y));
            end
            if (o_valid && !i_stall) begin
                if (expected_pixels.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected pixel beat: lit %0b colour %h",
                                 o_lit, o_pixel_color);
                    mismatches++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (o_lit !== want.lit || o_pixel_color !== want.color) begin
                        if (mismatches < 10)
                            $display("pixel mismatch: lit %0b/%0b colour %h/%h (exp/got)",
                                     want.lit, o_lit, want.color, o_pixel_color);
                        mismatches++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        string text;
        int i, phase;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty line at reset settings: nothing lit
        queue_query(0, 0);
        queue_query(2, 0);
        queue_query(159, 79);
        queue_query(255, 127);
        text = "Hi there 0123456789.-:/_?XyZ";
        for (i = 0; i < 28; i++)
            queue_store(5'(i), text[i]);
        queue_store(5'd28, 8'h00);
        queue_store(5'd29, 8'h7F);
        queue_store(5'd30, 8'h80);
        queue_store(5'd31, 8'hFF);
        wait_idle();

        configure(1, 0, 16'hFFFF, 32);
        queue_query(0, 0);
        queue_query(2, 0);
        queue_query(3, 1);
        queue_query(7, 3);
        queue_query(157, 6);
        queue_query(159, 6);
        queue_query(160, 3);
        queue_query(255, 0);
        queue_query(10, 7);
        queue_query(4, 127);
        wait_idle();

        configure(0, 1, 16'hA55A, 63);
        queue_query(2, 1);
        queue_query(4, 4);
        queue_query(100, 5);
        wait_idle();

        configure(7, 0, 16'h0000, 63);
        queue_query(20, 0);
        queue_query(27, 7);
        queue_query(55, 20);
        queue_query(40, 48);
        queue_query(146, 48);
        wait_idle();

        configure(4, 79, 16'hFFFF, 5);
        queue_query(22, 79);
        queue_query(30, 79);
        queue_query(22, 80);
        wait_idle();

        configure(2, 127, 16'h1234, 10);
        queue_query(50, 127);
        wait_idle();

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: configure(1, 0, 16'hF800, 20);
                1: configure(4, 79, 16'h0000, 63);
                2: configure(7, 60, 16'hFFFF, 3);
                3: configure(2, 40, 16'h07E0, 32);
                default: configure(($urandom_range(0, 3) == 0) ? $urandom_range(0, 7)
                                                               : $urandom_range(1, 4),
                                   ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127)
                                                               : $urandom_range(0, 79),
                                   $urandom_range(0, 65535), $urandom_range(0, 63));
            endcase
            for (i = 0; i < PHASE_BEATS; i++)
                queue_random_beat();
            if (phase == 3) pressure_req = 1'b1;
            wait_idle();
        end

        if (mismatches == 0 && expected_pixels.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/stlpg_pkg.sv
hw/rtl/scaled_text_line_pixel_generator_core.sv
sim/scaled_text_line_pixel_generator_core_tb.sv
